[rtl/core/bwe_pkg.sv]
package bwe_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned DEG_IN_W = 4;
  localparam int unsigned OP_W = 2;
  localparam int unsigned KIND_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_ADJ = 2'd0,
    OP_LOAD_DEG = 2'd1,
    OP_BEGIN    = 2'd2,
    OP_STEP     = 2'd3
  } op_t;

  localparam logic [KIND_W-1:0] KIND_EXPANDED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DISCOVERED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY      = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_BEGIN,
    ST_FETCH,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load_adj;
    logic load_deg;
    logic clr_start;
    logic clr_run;
    logic clr_deg;
    logic begin_walk;
    logic emit_empty;
    logic pop;
    logic fetch;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic queue_empty;
    logic scan_done;
  } stat_t;

endpackage

[rtl/core/bwe_ctrl.sv]
module bwe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     op,
  input  bwe_pkg::stat_t stat,
  output bwe_pkg::cmd_t  cmd,
  output logic           busy
);

  bwe_pkg::state_t state;
  bwe_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bwe_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      bwe_pkg::ST_INIT: begin
        cmd.clr_run = 1'b1;
        cmd.clr_deg = 1'b1;
        if (stat.clr_last) begin
          state_next = bwe_pkg::ST_IDLE;
        end
      end
      bwe_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (bwe_pkg::op_t'(op))
            bwe_pkg::OP_LOAD_ADJ: cmd.load_adj = 1'b1;
            bwe_pkg::OP_LOAD_DEG: cmd.load_deg = 1'b1;
            bwe_pkg::OP_BEGIN: begin
              cmd.clr_start = 1'b1;
              state_next = bwe_pkg::ST_CLEAR;
            end
            bwe_pkg::OP_STEP: begin
              if (stat.queue_empty) begin
                cmd.emit_empty = 1'b1;
              end else begin
                cmd.pop = 1'b1;
                state_next = bwe_pkg::ST_FETCH;
              end
            end
            default: state_next = bwe_pkg::ST_IDLE;
          endcase
        end
      end
      bwe_pkg::ST_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (stat.clr_last) begin
          state_next = bwe_pkg::ST_BEGIN;
        end
      end
      bwe_pkg::ST_BEGIN: begin
        cmd.begin_walk = 1'b1;
        state_next = bwe_pkg::ST_IDLE;
      end
      bwe_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = bwe_pkg::ST_SCAN;
      end
      bwe_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          cmd.finish = 1'b1;
          state_next = bwe_pkg::ST_IDLE;
        end
      end
      default: state_next = bwe_pkg::ST_INIT;
    endcase
  end

endmodule

[rtl/core/bwe_datapath.sv]
module bwe_datapath #(
  parameter int unsigned NODE_COUNT = 64,
  parameter int unsigned MAX_DEGREE = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bwe_pkg::cmd_t                 cmd,
  output bwe_pkg::stat_t                stat,
  input  logic                          cfg_wr_en,
  input  logic [bwe_pkg::NODE_W-1:0]    cfg_wr_data,
  input  logic [bwe_pkg::NODE_W-1:0]    node,
  input  logic [bwe_pkg::SLOT_W-1:0]    slot,
  input  logic [bwe_pkg::NODE_W-1:0]    neighbor,
  input  logic [bwe_pkg::DEG_IN_W-1:0]  degree,
  output logic                          strobe,
  output logic [bwe_pkg::KIND_W-1:0]    kind,
  output logic [bwe_pkg::NODE_W-1:0]    result_node,
  output logic                          last
);

  localparam int unsigned NW = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned CW = $clog2(NODE_COUNT + 1);
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned AW = (NODE_COUNT * MAX_DEGREE > 2) ?
                               $clog2(NODE_COUNT * MAX_DEGREE) : 1;
  localparam int unsigned NWD = bwe_pkg::NODE_W;

  logic [NWD-1:0] adj_mem [NODE_COUNT*MAX_DEGREE];
  logic [DW-1:0]  deg_mem [NODE_COUNT];
  logic           vis_mem [NODE_COUNT];
  logic [NWD-1:0] queue_mem [NODE_COUNT];

  logic [NWD-1:0] start_node;
  logic [NW-1:0]  clr_idx;
  logic [NW-1:0]  head;
  logic [NW-1:0]  tail;
  logic [CW-1:0]  count;
  logic [NWD-1:0] q_rd;
  logic [NWD-1:0] cur;
  logic [DW-1:0]  deg_q;
  logic [DW-1:0]  idx;
  logic           s1_v;
  logic [NWD-1:0] adj_q;
  logic           s2_v;
  logic [NWD-1:0] nb2;
  logic           vis_q;
  logic           mark_v;
  logic [NWD-1:0] mark_node;
  logic [bwe_pkg::KIND_W-1:0] pend_kind;
  logic [NWD-1:0] pend_node;

  logic           node_ok;
  logic           slot_ok;
  logic [DW-1:0]  deg_clamped;
  logic [NWD-1:0] start_clamped;
  logic [AW-1:0]  adj_waddr;
  logic [AW-1:0]  adj_raddr;
  logic           issue;
  logic           hit;
  logic           push_ok;

  assign node_ok = 32'(node) < NODE_COUNT;
  assign slot_ok = 32'(slot) < MAX_DEGREE;
  assign deg_clamped = (32'(degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(degree);
  assign start_clamped = (32'(start_node) >= NODE_COUNT) ? NWD'(NODE_COUNT - 1) :
                         start_node;
  assign adj_waddr = AW'(32'(node) * MAX_DEGREE + 32'(slot));
  assign adj_raddr = AW'(32'(cur) * MAX_DEGREE + 32'(idx));
  assign issue = cmd.scan && (idx < deg_q);
  assign hit = cmd.scan && s2_v && (32'(nb2) < NODE_COUNT) && !vis_q &&
               !(mark_v && (mark_node == nb2));
  assign push_ok = 32'(count) < NODE_COUNT;

  assign stat.clr_last = clr_idx == NW'(NODE_COUNT - 1);
  assign stat.queue_empty = count == '0;
  assign stat.scan_done = !(idx < deg_q) && !s1_v && !s2_v;

  always_ff @(posedge clk) begin
    if (cmd.load_adj && node_ok && slot_ok) begin
      adj_mem[adj_waddr] <= neighbor;
    end
    if (issue) begin
      adj_q <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_run && cmd.clr_deg) begin
      deg_mem[clr_idx] <= '0;
    end else if (cmd.load_deg && node_ok) begin
      deg_mem[NW'(node)] <= deg_clamped;
    end
    if (cmd.fetch) begin
      deg_q <= deg_mem[NW'(q_rd)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_run) begin
      vis_mem[clr_idx] <= 1'b0;
    end else if (cmd.begin_walk) begin
      vis_mem[NW'(start_clamped)] <= 1'b1;
    end else if (hit) begin
      vis_mem[NW'(nb2)] <= 1'b1;
    end
    if (cmd.scan && s1_v) begin
      vis_q <= vis_mem[NW'(adj_q)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_walk) begin
      queue_mem[0] <= start_clamped;
    end else if (hit && push_ok) begin
      queue_mem[tail] <= nb2;
    end
    if (cmd.pop) begin
      q_rd <= queue_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_node <= '0;
      clr_idx <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
      idx <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      mark_v <= 1'b0;
      strobe <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_node <= cfg_wr_data;
      end
      if (cmd.clr_start) begin
        clr_idx <= '0;
      end else if (cmd.clr_run) begin
        clr_idx <= stat.clr_last ? '0 : clr_idx + 1'b1;
      end
      if (cmd.begin_walk) begin
        head <= '0;
        tail <= NW'(1);
        count <= CW'(1);
      end else begin
        if (cmd.pop) begin
          head <= (head == NW'(NODE_COUNT - 1)) ? '0 : head + 1'b1;
          count <= count - 1'b1;
        end
        if (hit && push_ok) begin
          tail <= (tail == NW'(NODE_COUNT - 1)) ? '0 : tail + 1'b1;
          count <= count + 1'b1;
        end
      end
      if (cmd.fetch) begin
        idx <= '0;
        s1_v <= 1'b0;
        s2_v <= 1'b0;
        mark_v <= 1'b0;
      end else if (cmd.scan) begin
        if (issue) begin
          idx <= idx + 1'b1;
        end
        s1_v <= issue;
        s2_v <= s1_v;
        mark_v <= hit;
      end
      strobe <= cmd.emit_empty || cmd.begin_walk || hit || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      cur <= q_rd;
    end
    if (cmd.scan && s1_v) begin
      nb2 <= adj_q;
    end
    if (cmd.scan && s2_v) begin
      mark_node <= nb2;
    end
    if (cmd.fetch) begin
      pend_kind <= bwe_pkg::KIND_EXPANDED;
      pend_node <= q_rd;
    end else if (hit) begin
      pend_kind <= bwe_pkg::KIND_DISCOVERED;
      pend_node <= nb2;
    end
    if (cmd.emit_empty) begin
      kind <= bwe_pkg::KIND_EMPTY;
      result_node <= '0;
      last <= 1'b1;
    end else if (cmd.begin_walk) begin
      kind <= bwe_pkg::KIND_DISCOVERED;
      result_node <= start_clamped;
      last <= 1'b1;
    end else if (hit || cmd.finish) begin
      kind <= pend_kind;
      result_node <= pend_node;
      last <= cmd.finish;
    end
  end

endmodule

[rtl/core/bfs_walk_engine_unit.sv]
// Channel   Direction  Handshake                  Payload
// input     in         start high while busy low  op, node, slot, neighbor, degree
// result    out        strobe, one cycle per beat kind, result_node, last
// config    in         cfg_wr_en                  cfg_wr_data (start node)
//
// A load leaves the block idle; a step on an empty queue gives its beat in the next cycle.
// A step pops the queue, reads the node's degree, then scans its list through the
// adjacency memory, which delivers one neighbour entry per cycle.
// A begin clears the visited map a row per cycle, then marks and enqueues the start node.
// After reset the block clears its degree and visited memories, with busy high.
// The receiver cannot stall, so every beat goes out at once.
module bfs_walk_engine_unit #(
  parameter int unsigned NODE_COUNT = 64,
  parameter int unsigned MAX_DEGREE = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bwe_pkg::OP_W-1:0]      op,
  input  logic [bwe_pkg::NODE_W-1:0]    node,
  input  logic [bwe_pkg::SLOT_W-1:0]    slot,
  input  logic [bwe_pkg::NODE_W-1:0]    neighbor,
  input  logic [bwe_pkg::DEG_IN_W-1:0]  degree,
  input  logic                          cfg_wr_en,
  input  logic [bwe_pkg::NODE_W-1:0]    cfg_wr_data,
  output logic                          strobe,
  output logic [bwe_pkg::KIND_W-1:0]    kind,
  output logic [bwe_pkg::NODE_W-1:0]    result_node,
  output logic                          last
);

  bwe_pkg::cmd_t  cmd;
  bwe_pkg::stat_t stat;

  bwe_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (op),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  bwe_datapath #(
    .NODE_COUNT(NODE_COUNT),
    .MAX_DEGREE(MAX_DEGREE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .node       (node),
    .slot       (slot),
    .neighbor   (neighbor),
    .degree     (degree),
    .strobe     (strobe),
    .kind       (kind),
    .result_node(result_node),
    .last       (last)
  );

  a_step_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == bwe_pkg::OP_STEP)) |=> (busy || (strobe && last)))
    else $error("accepted step neither started nor answered");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((op == bwe_pkg::OP_LOAD_ADJ) || (op == bwe_pkg::OP_LOAD_DEG)))
    |=> !strobe)
    else $error("load produced a result beat");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (strobe && (kind == bwe_pkg::KIND_EMPTY)) |-> (last && (result_node == '0)))
    else $error("empty beat malformed");

  a_no_beat_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && !$past(busy) && !$past(start)) |-> 1'b0)
    else $error("result beat without work in progress");

endmodule
